### src/fall_detection_classifier_top_defines.svh
// Assertion macros used by the fall detection classifier top level
`ifndef FALL_DETECTION_CLASSIFIER_TOP_DEFINES_SVH
`define FALL_DETECTION_CLASSIFIER_TOP_DEFINES_SVH

// implication checked in the same cycle
`define FDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fdc check failed");

// implication checked in the following cycle
`define FDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fdc check failed");

`endif

### src/fdc_pkg.sv
// Types and constants of the fall detection classifier
package fdc_pkg;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned CODE_W     = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_FALL_THR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GYRO_FALL_THR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY_THR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_TIME      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_URGENT_TIME    = 3'd4;

   // event codes of a result item
   typedef enum logic [CODE_W-1:0] {
      EV_NONE     = 3'd0,
      EV_POSSIBLE = 3'd1,
      EV_URGENT   = 3'd2,
      EV_RECOVERY = 3'd3,
      EV_MILD     = 3'd4,
      EV_FALSE    = 3'd5
   } ev_type;

   // configuration seen by the classifier
   typedef struct packed {
      logic [CSR_DATA_W-1:0] accel_fall_thr;
      logic [CSR_DATA_W-1:0] gyro_fall_thr;
      logic [CSR_DATA_W-1:0] recovery_thr;
      logic [TIME_W-1:0]     fall_time;
      logic [TIME_W-1:0]     urgent_time;
   } cfg_type;

endpackage

### src/fdc_req_if.sv
// Sample channel: six inertial axes and a millisecond timestamp
interface fdc_req_if #(
   parameter int unsigned SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] accel_x;
   logic signed [SAMPLE_BITS-1:0] accel_y;
   logic signed [SAMPLE_BITS-1:0] accel_z;
   logic signed [SAMPLE_BITS-1:0] gyro_x;
   logic signed [SAMPLE_BITS-1:0] gyro_y;
   logic signed [SAMPLE_BITS-1:0] gyro_z;
   logic [31:0]                   now_ms;

   modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                   now_ms, input ready);
   modport sink (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
                 now_ms, output ready);
endinterface

### src/fdc_rsp_if.sv
// Result channel: event code and indicator state
interface fdc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_code;
   logic       indicator_on;

   modport source (output valid, event_code, indicator_on, input ready);
   modport sink (input valid, event_code, indicator_on, output ready);
endinterface

### src/fall_detection_classifier_top.sv
// Sample accept to result valid: registered square lanes, then the merge stage.
// Throughput: one sample per cycle while the receiver takes results; six squaring
// lanes run in parallel and the merge stage updates the fall state once per item.
// Reset (synchronous, active high) clears the pipeline, the fall state and all
// configuration registers; no clearing pass is needed.
`include "fall_detection_classifier_top_defines.svh"

// Top level of the fall detection classifier
module fall_detection_classifier_top
   import fdc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   fdc_req_if.sink               req_chan,
   fdc_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

   cfg_type                       cfg_ff, cfg_in;
   logic signed [SAMPLE_BITS-1:0] axis [6];
   logic [SQ_W-1:0]               sq [6];
   logic                          req_fire;
   logic                          in_ready;
   ev_type                        code;

   // configuration register writes; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ACCEL_FALL_THR: cfg_in.accel_fall_thr = csr_wr_data;
            CSR_GYRO_FALL_THR:  cfg_in.gyro_fall_thr  = csr_wr_data;
            CSR_RECOVERY_THR:   cfg_in.recovery_thr   = csr_wr_data;
            CSR_FALL_TIME:      cfg_in.fall_time      = csr_wr_data;
            CSR_URGENT_TIME:    cfg_in.urgent_time    = csr_wr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sample acceptance
   assign req_chan.ready = in_ready;
   assign req_fire       = req_chan.valid & in_ready;

   assign axis[0] = req_chan.accel_x;
   assign axis[1] = req_chan.accel_y;
   assign axis[2] = req_chan.accel_z;
   assign axis[3] = req_chan.gyro_x;
   assign axis[4] = req_chan.gyro_y;
   assign axis[5] = req_chan.gyro_z;

   // squaring lanes, one per axis
   for (genvar i = 0; i < 6; i++) begin : g_lane
      fdc_sq_lane #(
         .SAMPLE_BITS(SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .load   (req_fire),
         .sample (axis[i]),
         .sq     (sq[i])
      );
   end

   // magnitude merge and classification
   fdc_merge #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_load      (req_fire),
      .in_ready     (in_ready),
      .now_ms       (req_chan.now_ms),
      .sq           (sq),
      .cfg          (cfg_ff),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .event_code   (code),
      .indicator_on (rsp_chan.indicator_on)
   );

   assign rsp_chan.event_code = code;

   // alerts that light the indicator
   `FDC_ASSERT_IMP(a_alert_lit, clock, reset,
      rsp_chan.valid && (code == EV_POSSIBLE || code == EV_URGENT), rsp_chan.indicator_on)
   // classification ends the fall and darkens the indicator
   `FDC_ASSERT_IMP(a_close_dark, clock, reset,
      rsp_chan.valid && (code == EV_RECOVERY || code == EV_MILD || code == EV_FALSE),
      !rsp_chan.indicator_on)
   // an accepted sample into an empty pipeline holds the square stage next cycle
   `FDC_ASSERT_NEXT(a_flow, clock, reset,
      req_fire && !rsp_chan.valid && !u_merge.s1_valid_ff, u_merge.s1_valid_ff)
endmodule

### src/fdc_sq_lane.sv
// One squaring lane: absolute value of an axis sample, squared and registered
module fdc_sq_lane
   import fdc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            load,
   input  logic signed [SAMPLE_BITS-1:0]   sample,
   output logic        [2*SAMPLE_BITS-1:0] sq
);
   localparam int unsigned SQ_W = 2 * SAMPLE_BITS;

   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] mag;
   logic [SQ_W-1:0]        sq_in;
   logic [SQ_W-1:0]        sq_ff;

   // magnitude; the most negative value maps to 2^(SAMPLE_BITS-1)
   assign raw   = sample;
   assign mag   = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
   assign sq_in = SQ_W'(mag) * SQ_W'(mag);

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

   assign sq = sq_ff;
endmodule

### src/fdc_merge.sv
// Merge stage: sums lane squares, compares thresholds, runs the fall state
module fdc_merge
   import fdc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_load,
   output logic                         in_ready,
   input  logic [TIME_W-1:0]            now_ms,
   input  logic [2*SAMPLE_BITS-1:0]     sq [6],
   input  cfg_type                      cfg,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output ev_type                       event_code,
   output logic                         indicator_on
);
   localparam int unsigned SUM_W = 2 * SAMPLE_BITS + 2;
   localparam int unsigned CMP_W = (SUM_W > CSR_DATA_W) ? SUM_W : CSR_DATA_W;

   logic              s1_valid_ff, s1_valid_in;
   logic [TIME_W-1:0] now_s1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   ev_type            code_ff, code_in;
   logic              ind_out_ff;

   logic              pend_ff, pend_in;
   logic              urg_ff, urg_in;
   logic [TIME_W-1:0] start_ff, start_in;
   logic              ind_ff, ind_in;

   logic              advance, fire;
   logic [CMP_W-1:0]  acc_sq, gyr_sq;
   logic [TIME_W-1:0] elapsed;
   logic              urgent;

   // pipeline flow: result register drains or is empty
   assign advance  = ~rsp_valid_ff | rsp_ready;
   assign in_ready = ~s1_valid_ff | advance;
   assign fire     = s1_valid_ff & advance;

   assign s1_valid_in  = in_ready ? in_load : s1_valid_ff;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // vector magnitudes from the lanes
   assign acc_sq = CMP_W'(sq[0]) + CMP_W'(sq[1]) + CMP_W'(sq[2]);
   assign gyr_sq = CMP_W'(sq[3]) + CMP_W'(sq[4]) + CMP_W'(sq[5]);

   // wrapping elapsed time since fall start
   assign elapsed = now_s1_ff - start_ff;
   assign urgent  = urg_ff | (elapsed >= cfg.urgent_time);

   // classifier next state
   always_comb begin
      pend_in  = pend_ff;
      urg_in   = urg_ff;
      start_in = start_ff;
      ind_in   = ind_ff;
      code_in  = EV_NONE;
      if (!pend_ff && (acc_sq >= CMP_W'(cfg.accel_fall_thr))
          && (gyr_sq >= CMP_W'(cfg.gyro_fall_thr))) begin
         pend_in  = 1'b1;
         start_in = now_s1_ff;
         ind_in   = 1'b1;
         code_in  = EV_POSSIBLE;
      end else if (pend_ff) begin
         if (acc_sq <= CMP_W'(cfg.recovery_thr)) begin
            if (urgent) begin
               urg_in  = 1'b0;
               code_in = EV_RECOVERY;
            end else if (elapsed >= cfg.fall_time) begin
               code_in = EV_MILD;
            end else begin
               code_in = EV_FALSE;
            end
            pend_in  = 1'b0;
            start_in = '0;
            ind_in   = 1'b0;
         end else if (urgent && !urg_ff) begin
            urg_in  = 1'b1;
            ind_in  = 1'b1;
            code_in = EV_URGENT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         urg_ff       <= 1'b0;
         start_ff     <= '0;
         ind_ff       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            pend_ff  <= pend_in;
            urg_ff   <= urg_in;
            start_ff <= start_in;
            ind_ff   <= ind_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         now_s1_ff <= now_ms;
      end
      if (fire) begin
         code_ff    <= code_in;
         ind_out_ff <= ind_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign event_code   = code_ff;
   assign indicator_on = ind_out_ff;
endmodule

### tb/fall_event_checker.sv
// Checker for the fall detection classifier: predicts each result item and compares
`timescale 1ns / 1ps

module fall_event_checker
   import fdc_pkg::*;
#(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] accel_x,
   input  logic signed [SAMPLE_BITS-1:0] accel_y,
   input  logic signed [SAMPLE_BITS-1:0] accel_z,
   input  logic signed [SAMPLE_BITS-1:0] gyro_x,
   input  logic signed [SAMPLE_BITS-1:0] gyro_y,
   input  logic signed [SAMPLE_BITS-1:0] gyro_z,
   input  logic [TIME_W-1:0]             now_ms,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [CODE_W-1:0]             event_code,
   input  logic                          indicator_on,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data,
   output int                            fail_count,
   output int                            outstanding
);

   typedef struct packed {
      ev_type code;
      logic   lamp;
   } verdict_type;

   // shadow of the configuration and the fall state
   cfg_type           cfg;
   logic              fall_pending;
   logic              urgent_raised;
   logic              lamp;
   logic [TIME_W-1:0] fall_start;
   verdict_type       expected_events[$];
   int                fails = 0;

   // exact squared magnitude of a three axis vector
   function automatic logic [63:0] sq_mag(logic signed [SAMPLE_BITS-1:0] x,
                                          logic signed [SAMPLE_BITS-1:0] y,
                                          logic signed [SAMPLE_BITS-1:0] z);
      longint a, b, c;
      a = x;
      b = y;
      c = z;
      return a * a + b * b + c * c;
   endfunction

   // classify one sample, update the fall state and queue the expected item
   task automatic classify_sample(input logic [63:0] acc_sq, input logic [63:0] gyr_sq,
                                  input logic [TIME_W-1:0] now);
      verdict_type       v;
      logic [TIME_W-1:0] elapsed;
      logic              urgent;
      v.code = EV_NONE;
      if (!fall_pending && acc_sq >= {32'd0, cfg.accel_fall_thr} &&
          gyr_sq >= {32'd0, cfg.gyro_fall_thr}) begin
         fall_pending = 1'b1;
         fall_start   = now;
         lamp         = 1'b1;
         v.code       = EV_POSSIBLE;
      end else if (fall_pending) begin
         elapsed = now - fall_start;
         urgent  = urgent_raised || (elapsed >= cfg.urgent_time);
         if (acc_sq <= {32'd0, cfg.recovery_thr}) begin
            // wearer is still again: grade by elapsed time, then clear
            if (urgent) begin
               urgent_raised = 1'b0;
               v.code        = EV_RECOVERY;
            end else if (elapsed >= cfg.fall_time) begin
               v.code = EV_MILD;
            end else begin
               v.code = EV_FALSE;
            end
            fall_pending = 1'b0;
            fall_start   = '0;
            lamp         = 1'b0;
         end else if (urgent && !urgent_raised) begin
            // single urgent alert per fall
            urgent_raised = 1'b1;
            lamp          = 1'b1;
            v.code        = EV_URGENT;
         end
      end
      v.lamp = lamp;
      expected_events.push_back(v);
   endtask

   always @(posedge clock) begin : watch
      verdict_type got;
      verdict_type want;
      if (reset) begin
         cfg           = '0;
         fall_pending  = 1'b0;
         urgent_raised = 1'b0;
         lamp          = 1'b0;
         fall_start    = '0;
         expected_events.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ACCEL_FALL_THR: cfg.accel_fall_thr = csr_wr_data;
               CSR_GYRO_FALL_THR:  cfg.gyro_fall_thr  = csr_wr_data;
               CSR_RECOVERY_THR:   cfg.recovery_thr   = csr_wr_data;
               CSR_FALL_TIME:      cfg.fall_time      = csr_wr_data;
               CSR_URGENT_TIME:    cfg.urgent_time    = csr_wr_data;
               default: ;
            endcase
         end
         // accepted sample
         if (req_valid && req_ready)
            classify_sample(sq_mag(accel_x, accel_y, accel_z),
                            sq_mag(gyro_x, gyro_y, gyro_z), now_ms);
         // accepted result
         if (rsp_valid && rsp_ready) begin
            got.code = ev_type'(event_code);
            got.lamp = indicator_on;
            if (expected_events.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: result item with no sample waiting: code %0d lamp %0b",
                           $realtime, event_code, indicator_on);
            end else begin
               want = expected_events.pop_front();
               if (got.code !== want.code || got.lamp !== want.lamp) begin
                  fails++;
                  if (fails <= 10)
                     $display("%0t: mismatch: expected code %0d lamp %0b, got code %0d lamp %0b",
                              $realtime, want.code, want.lamp, event_code, indicator_on);
               end
            end
         end
      end
      fail_count  <= fails;
      outstanding <= expected_events.size();
   end

endmodule

### tb/tb.sv
// Testbench top: clock, reset, sample and register stimulus, receiver stalls, verdict
`timescale 1ns / 1ps

module tb;
   import fdc_pkg::*;

   localparam int unsigned SAMPLE_BITS       = 16;
   localparam int          RUN_LIMIT         = 500000;
   localparam int          HOLD_CYCLES       = 300;
   localparam int          ITEMS_PER_SETTING = 200;
   localparam int unsigned FULL_SCALE        = 32768;
   localparam logic [31:0] MAG_SQ_MAX        = 32'd3221225472;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_SPARE = CSR_URGENT_TIME + CSR_IDX_W'(1);
   localparam int IDLE_MODE[4]  = '{0, 67, 0, 25};
   localparam int STALL_MODE[4] = '{0, 0, 67, 25};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   int                    chk_fails;
   int                    chk_outstanding;

   // stimulus state
   cfg_type     cur_cfg;
   int unsigned acc_lvl, gyr_lvl, rec_lvl;
   logic [31:0] stamp_ms;
   int          idle_pct  = 0;
   int          stall_pct = 0;
   int          hold_reqs = 0;
   int          sent      = 0;

   fdc_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_chan ();
   fdc_rsp_if rsp_chan ();

   fall_detection_classifier_top #(.SAMPLE_BITS(SAMPLE_BITS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   fall_event_checker #(.SAMPLE_BITS(SAMPLE_BITS)) event_chk (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_chan.valid),
      .req_ready    (req_chan.ready),
      .accel_x      (req_chan.accel_x),
      .accel_y      (req_chan.accel_y),
      .accel_z      (req_chan.accel_z),
      .gyro_x       (req_chan.gyro_x),
      .gyro_y       (req_chan.gyro_y),
      .gyro_z       (req_chan.gyro_z),
      .now_ms       (req_chan.now_ms),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .event_code   (rsp_chan.event_code),
      .indicator_on (rsp_chan.indicator_on),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (chk_fails),
      .outstanding  (chk_outstanding)
   );

   always #10 clock = ~clock;

   // axis value uniform in [-amp, amp], clipped to FULL_SCALE-1 at the top
   function automatic logic signed [15:0] rand_axis(int unsigned amp);
      int v;
      v = int'($urandom_range(2 * amp)) - int'(amp);
      if (v > int'(FULL_SCALE) - 1) v = int'(FULL_SCALE) - 1;
      return 16'(v);
   endfunction

   // axis value with magnitude at least lvl (positive values clipped to FULL_SCALE-1), random sign
   function automatic logic signed [15:0] loud_axis(int unsigned lvl);
      int m;
      m = int'($urandom_range(FULL_SCALE, lvl));
      if ($urandom_range(1) == 1) m = -m;
      if (m > int'(FULL_SCALE) - 1) m = int'(FULL_SCALE) - 1;
      return 16'(m);
   endfunction

   // amplitude around the current threshold levels
   function automatic int unsigned pick_amp();
      case ($urandom_range(5))
         0:       return 0;
         1:       return rec_lvl;
         2:       return acc_lvl;
         3:       return gyr_lvl;
         4:       return $urandom_range(FULL_SCALE);
         default: return FULL_SCALE;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // write all registers, plus one write to an unused index that must be ignored
   task automatic set_config(input cfg_type c);
      logic [CSR_IDX_W-1:0] spare;
      spare = CSR_IDX_SPARE + CSR_IDX_W'($urandom_range(2));
      csr_write(CSR_ACCEL_FALL_THR, c.accel_fall_thr);
      csr_write(CSR_GYRO_FALL_THR, c.gyro_fall_thr);
      csr_write(CSR_RECOVERY_THR, c.recovery_thr);
      csr_write(CSR_FALL_TIME, c.fall_time);
      csr_write(CSR_URGENT_TIME, c.urgent_time);
      csr_write(spare, $urandom());
      csr_wr_en <= 1'b0;
      cur_cfg = c;
   endtask

   // random thresholds, mostly three times the square of an axis level so falls can start
   task automatic pick_config();
      cfg_type c;
      acc_lvl = $urandom_range(FULL_SCALE);
      gyr_lvl = $urandom_range(FULL_SCALE);
      rec_lvl = $urandom_range(acc_lvl);
      if ($urandom_range(7) == 0) begin
         c.accel_fall_thr = $urandom_range(MAG_SQ_MAX);
         c.gyro_fall_thr  = $urandom_range(MAG_SQ_MAX);
         c.recovery_thr   = $urandom_range(MAG_SQ_MAX);
         c.fall_time      = $urandom();
         c.urgent_time    = $urandom();
      end else begin
         c.accel_fall_thr = 3 * acc_lvl * acc_lvl;
         c.gyro_fall_thr  = 3 * gyr_lvl * gyr_lvl;
         c.recovery_thr   = 3 * rec_lvl * rec_lvl;
         c.fall_time      = $urandom_range(1000);
         if ($urandom_range(3) == 0)
            c.urgent_time = $urandom_range(c.fall_time);
         else
            c.urgent_time = c.fall_time + $urandom_range(4000);
      end
      set_config(c);
   endtask

   // offer one item, with random sender gaps, and wait until it is taken
   task automatic offer_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                               input logic signed [15:0] az, input logic signed [15:0] gx,
                               input logic signed [15:0] gy, input logic signed [15:0] gz,
                               input logic [31:0] ms);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.accel_x <= ax;
      req_chan.accel_y <= ay;
      req_chan.accel_z <= az;
      req_chan.gyro_x  <= gx;
      req_chan.gyro_y  <= gy;
      req_chan.gyro_z  <= gz;
      req_chan.now_ms  <= ms;
      do @(posedge clock); while (!req_chan.ready);
      sent++;
   endtask

   task automatic offer_random(input int unsigned amp_a, input int unsigned amp_g,
                               input logic [31:0] step);
      stamp_ms = stamp_ms + step;
      offer_sample(rand_axis(amp_a), rand_axis(amp_a), rand_axis(amp_a),
                   rand_axis(amp_g), rand_axis(amp_g), rand_axis(amp_g), stamp_ms);
   endtask

   // unstructured item, with an occasional large time jump
   task automatic stray_sample();
      logic [31:0] step;
      if ($urandom_range(24) == 0) step = $urandom();
      else step = $urandom_range(300);
      offer_random(pick_amp(), pick_amp(), step);
   endtask

   // start a fall, keep moving for a while, then mostly settle down
   task automatic fall_episode();
      int unsigned n_hold, span, step_max;
      span     = (cur_cfg.urgent_time > 60000) ? 60000 : cur_cfg.urgent_time;
      n_hold   = $urandom_range(12);
      step_max = 3 * span / (n_hold + 1) + 1;
      stamp_ms = stamp_ms + $urandom_range(50);
      offer_sample(loud_axis(acc_lvl), loud_axis(acc_lvl), loud_axis(acc_lvl),
                   loud_axis(gyr_lvl), loud_axis(gyr_lvl), loud_axis(gyr_lvl), stamp_ms);
      repeat (n_hold) begin
         if ($urandom_range(5) == 0) begin
            offer_random(pick_amp(), pick_amp(), $urandom_range(step_max));
         end else begin
            stamp_ms = stamp_ms + $urandom_range(step_max);
            offer_sample(loud_axis(rec_lvl), loud_axis(rec_lvl), loud_axis(rec_lvl),
                         rand_axis(pick_amp()), rand_axis(pick_amp()), rand_axis(pick_amp()),
                         stamp_ms);
         end
      end
      if ($urandom_range(9) != 0)
         offer_random(($urandom_range(3) == 0) ? 0 : rec_lvl / 2, pick_amp(),
                      $urandom_range(step_max));
   endtask

   // stop sending and wait for every expected item, plus the pipeline depth
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (chk_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver: random stalls, and a long hold-off on request
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // run limit
   initial begin : watchdog
      repeat (RUN_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int phase;
      int half;
      int target;
      reset            <= 1'b1;
      csr_wr_en        <= 1'b0;
      csr_index        <= '0;
      csr_wr_data      <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.accel_x <= '0;
      req_chan.accel_y <= '0;
      req_chan.accel_z <= '0;
      req_chan.gyro_x  <= '0;
      req_chan.gyro_y  <= '0;
      req_chan.gyro_z  <= '0;
      req_chan.now_ms  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: small thresholds so exact boundaries are reachable
      set_config('{accel_fall_thr: 32'd30000, gyro_fall_thr: 32'd30000,
                   recovery_thr: 32'd7500, fall_time: 32'd300, urgent_time: 32'd2000});
      // still sample, then gyro one step short of the threshold
      offer_sample('0, '0, '0, '0, '0, '0, 32'd1000);
      offer_sample(16'sd100, 16'sd100, 16'sd100, 16'sd99, 16'sd100, 16'sd100, 32'd1000);
      // both exactly at threshold: fall starts; then early settle is a false detection
      offer_sample(16'sd100, -16'sd100, 16'sd100, -16'sd100, 16'sd100, 16'sd100, 32'd1010);
      offer_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0, '0, '0, 32'd1100);
      offer_sample(16'sd50, -16'sd50, 16'sd50, '0, '0, '0, 32'd1200);
      // full negative scale starts a fall; settle exactly at fall time is mild
      offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 32'd5000);
      offer_sample(16'sd51, 16'sd50, 16'sd50, '0, '0, '0, 32'd5300);
      offer_sample('0, '0, '0, '0, '0, '0, 32'd5300);
      // fall across the timestamp wrap, urgent exactly at urgent time, then recovery
      offer_sample(16'sh7FFF, 16'sh8000, '0, '0, 16'sh7FFF, 16'sh8000, 32'hFFFF_FF00);
      offer_sample(16'sd20000, '0, '0, '0, '0, '0, 32'h0000_06D0);
      offer_sample(-16'sd20000, '0, '0, '0, '0, '0, 32'h0000_0800);
      offer_sample('0, '0, '0, '0, '0, '0, 32'h0000_0900);
      // zero elapsed settle, then accel one step short of the threshold
      offer_sample(16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 32'h0000_1000);
      offer_sample('0, '0, '0, '0, '0, '0, 32'h0000_1000);
      offer_sample(16'sd100, 16'sd100, 16'sd99, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h0000_1100);
      wait_idle();

      // all registers zero: any sample starts a fall when none is pending, urgent at once
      set_config('0);
      offer_sample('0, '0, '0, '0, '0, '0, 32'd0);
      offer_sample('0, '0, '0, '0, '0, '0, 32'd0);
      offer_sample('0, '0, '0, '0, '0, '0, 32'd3);
      offer_sample(16'sd1, '0, '0, '0, '0, '0, 32'd7);
      offer_sample(-16'sd1, '0, '0, '0, '0, '0, 32'd9);
      offer_sample('0, '0, '0, '0, '0, '0, 32'd11);
      wait_idle();

      // thresholds at the largest squared magnitude, times at all ones
      set_config('{MAG_SQ_MAX, MAG_SQ_MAX, MAG_SQ_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   32'h8000_0000);
      offer_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, '0, '0, '0, 32'h7FFF_FFFF);
      offer_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                   32'h1234_5678);
      offer_sample('0, '0, '0, '0, '0, '0, 32'h1234_5676);

      // random phases, two register settings each
      for (phase = 0; phase < 4; phase++) begin
         idle_pct  = IDLE_MODE[phase];
         stall_pct = STALL_MODE[phase];
         for (half = 0; half < 2; half++) begin
            wait_idle();
            pick_config();
            stamp_ms = $urandom();
            if (phase == 0 && half == 0) begin
               // receiver holds off while items keep coming: the block must back up
               hold_reqs++;
               repeat (24) stray_sample();
            end
            target = sent + ITEMS_PER_SETTING;
            while (sent < target) begin
               if ($urandom_range(3) != 0) fall_episode();
               else stray_sample();
            end
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (chk_fails == 0 && chk_outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### fall_detection_classifier_top.f
+incdir+src
src/fdc_pkg.sv
src/fdc_req_if.sv
src/fdc_rsp_if.sv
src/fdc_sq_lane.sv
src/fdc_merge.sv
src/fall_detection_classifier_top.sv
tb/fall_event_checker.sv
tb/tb.sv
